FILE: src/range_scan_reply_parser_assert.svh
// assertion macros for the range scan reply parser
// expects clk_i and rst_ni in the scope of the including module
`ifndef RANGE_SCAN_REPLY_PARSER_ASSERT_SVH
`define RANGE_SCAN_REPLY_PARSER_ASSERT_SVH

// property must hold at every clock edge out of reset
`define RSRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RSRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/rsrp_pkg.sv
// shared types and constants of the range scan reply parser
// no dependencies
package rsrp_pkg;

  localparam int unsigned MAX_VALUES_DEF = 1024;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned DistW  = 18;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned CountW = 11;
  localparam int unsigned CharsW = 7;
  localparam int unsigned HeldW  = 12;
  localparam int unsigned SixW   = 6;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 3;

  localparam logic [ByteW-1:0]  CH_M    = 8'h4D;
  localparam logic [ByteW-1:0]  CH_D    = 8'h44;
  localparam logic [ByteW-1:0]  CH_9    = 8'h39;
  localparam logic [ByteW-1:0]  CH_B    = 8'h62;
  localparam logic [ByteW-1:0]  CH_LF   = 8'h0A;
  localparam logic [ByteW-1:0]  CH_ZERO = 8'h30;

  localparam logic [CharsW-1:0] CHARS_RESET = 7'd65;
  localparam logic [CharsW-1:0] CHARS_MIN   = 7'd2;

  localparam logic REG_CHARS = 1'b0;

  typedef enum logic [2:0] {
    PH_ECHO1     = 3'd0,
    PH_ECHO2     = 3'd1,
    PH_ECHO_REST = 3'd2,
    PH_STATUS    = 3'd3,
    PH_STAMP     = 3'd4,
    PH_DATA      = 3'd5,
    PH_SKIP      = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DIST       = 2'd0,
    KIND_DONE       = 2'd1,
    KIND_BAD_ECHO   = 2'd2,
    KIND_BAD_STATUS = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [DistW-1:0]   distance;
    logic [IdxW-1:0]    idx;
    logic [CountW-1:0]  cnt;
  } result_t;

endpackage

FILE: src/range_scan_reply_parser.sv
// range scan reply parser: byte-wise decoder of the rangefinder MD reply
// depends on rsrp_pkg and range_scan_reply_parser_assert.svh
//
// input channel: one reply byte per transfer on rx_byte_i (in_valid_i / in_stall_o)
// output channel: one result per transfer (out_valid_o / out_stall_i), kind_o
//   selects distance, scan done, bad echo or bad status; distance_o and
//   value_index_o carry a decoded distance, scan_count_o the count of a done
// config: APB register 0 at address 0 holds data chars plus checksum per line
// each byte is parsed in the cycle it is taken; a result it causes is registered
//   into the output register, or into the skid register while a result waits
// throughput: one byte per cycle while in_stall_o is low, set by the combinational
//   parse logic between the incoming byte and the output register
// a two-entry output stage (output register plus skid register) lets a byte
//   be taken while a result waits; in_stall_o rises only once both entries are
//   full, and drops again the cycle after the receiver takes a result
// reset empties the output stage and returns the parser to the first echo
//   byte with the register at 65
module range_scan_reply_parser
  import rsrp_pkg::*;
#(
  parameter int unsigned MAX_VALUES = MAX_VALUES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ByteW-1:0]    rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          kind_o,
  output logic [DistW-1:0]    distance_o,
  output logic [IdxW-1:0]     value_index_o,
  output logic [CountW-1:0]   scan_count_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]    prdata,
  output logic                pready
);

  localparam int unsigned SeenW = $clog2(MAX_VALUES + 1);

  logic [CharsW-1:0] chars_q;
  phase_e            phase_q, phase_d;
  logic              first_m_q, first_m_d;
  logic [1:0]        stat_pos_q, stat_pos_d;
  logic              stat_good_q, stat_good_d;
  logic [HeldW-1:0]  held_q, held_d;
  logic [1:0]        grp_q, grp_d;
  logic [CharsW-1:0] line_q, line_d;
  logic [SeenW-1:0]  seen_q, seen_d;
  logic              prev_lf_q, prev_lf_d;

  logic              in_acc, out_take, is_lf, at_sum, full;
  logic [CharsW-1:0] per_line;
  logic [SixW-1:0]   six;
  logic [ByteW-1:0]  offset;

  logic              res_valid;
  result_t           res;
  result_t           out_q, skid_q;
  logic              out_valid_q, skid_valid_q;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CHARS) ? DataW'(chars_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_q <= CHARS_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CHARS)) begin
      chars_q <= pwdata[CharsW-1:0];
    end
  end

  // handshakes
  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i && !skid_valid_q;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;

  // byte decode
  assign is_lf    = (rx_byte_i == CH_LF);
  assign per_line = (chars_q < CHARS_MIN) ? CHARS_MIN : chars_q;
  assign at_sum   = (line_q >= (per_line - CharsW'(1)));
  assign offset   = rx_byte_i - CH_ZERO;
  assign six      = offset[SixW-1:0];
  assign full     = (seen_q >= SeenW'(MAX_VALUES));

  // next state
  always_comb begin
    phase_d     = phase_q;
    first_m_d   = first_m_q;
    stat_pos_d  = stat_pos_q;
    stat_good_d = stat_good_q;
    held_d      = held_q;
    grp_d       = grp_q;
    line_d      = line_q;
    seen_d      = seen_q;
    prev_lf_d   = prev_lf_q;
    unique case (phase_q)
      PH_ECHO1: begin
        first_m_d = (rx_byte_i == CH_M);
        phase_d   = PH_ECHO2;
      end
      PH_ECHO2: begin
        phase_d = (first_m_q && rx_byte_i == CH_D) ? PH_ECHO_REST : PH_SKIP;
      end
      PH_ECHO_REST: begin
        if (is_lf) begin
          phase_d     = PH_STATUS;
          stat_pos_d  = '0;
          stat_good_d = 1'b1;
        end
      end
      PH_STATUS: begin
        if (stat_pos_q == 2'd3) begin
          stat_pos_d  = '0;
          stat_good_d = 1'b1;
          phase_d     = stat_good_q ? PH_STAMP : PH_SKIP;
        end else begin
          if ((stat_pos_q == 2'd2) ? (rx_byte_i != CH_B) : (rx_byte_i != CH_9)) begin
            stat_good_d = 1'b0;
          end
          stat_pos_d = stat_pos_q + 2'd1;
        end
      end
      PH_STAMP: begin
        if (is_lf) begin
          phase_d   = PH_DATA;
          held_d    = '0;
          grp_d     = '0;
          line_d    = '0;
          seen_d    = '0;
          prev_lf_d = 1'b0;
        end
      end
      PH_DATA: begin
        if (is_lf) begin
          line_d = '0;
          if (prev_lf_q) begin
            phase_d   = PH_ECHO1;
            grp_d     = '0;
            held_d    = '0;
            prev_lf_d = 1'b0;
          end else begin
            prev_lf_d = 1'b1;
          end
        end else begin
          prev_lf_d = 1'b0;
          if (at_sum) begin
            line_d = '0;
          end else begin
            line_d = line_q + CharsW'(1);
            if (grp_q < 2'd2) begin
              held_d = {held_q[HeldW-SixW-1:0], six};
              grp_d  = grp_q + 2'd1;
            end else begin
              grp_d  = '0;
              held_d = '0;
              if (!full) begin
                seen_d = seen_q + SeenW'(1);
              end
            end
          end
        end
      end
      PH_SKIP: begin
        if (is_lf) begin
          phase_d = PH_ECHO1;
        end
      end
      default: begin
        phase_d = PH_ECHO1;
      end
    endcase
  end

  // result of the current byte
  always_comb begin
    res_valid    = 1'b0;
    res.kind     = KIND_DIST;
    res.distance = '0;
    res.idx      = '0;
    res.cnt      = '0;
    unique case (phase_q)
      PH_ECHO2: begin
        if (!(first_m_q && rx_byte_i == CH_D)) begin
          res_valid = 1'b1;
          res.kind  = KIND_BAD_ECHO;
        end
      end
      PH_STATUS: begin
        if (stat_pos_q == 2'd3 && !stat_good_q) begin
          res_valid = 1'b1;
          res.kind  = KIND_BAD_STATUS;
        end
      end
      PH_DATA: begin
        if (is_lf) begin
          if (prev_lf_q) begin
            res_valid = 1'b1;
            res.kind  = KIND_DONE;
            res.cnt   = CountW'(seen_q);
          end
        end else if (!at_sum && grp_q == 2'd2 && !full) begin
          res_valid    = 1'b1;
          res.kind     = KIND_DIST;
          res.distance = {held_q, six};
          res.idx      = IdxW'(seen_q);
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_ECHO1;
      first_m_q   <= 1'b0;
      stat_pos_q  <= '0;
      stat_good_q <= 1'b1;
      held_q      <= '0;
      grp_q       <= '0;
      line_q      <= '0;
      seen_q      <= '0;
      prev_lf_q   <= 1'b0;
    end else if (in_acc) begin
      phase_q     <= phase_d;
      first_m_q   <= first_m_d;
      stat_pos_q  <= stat_pos_d;
      stat_good_q <= stat_good_d;
      held_q      <= held_d;
      grp_q       <= grp_d;
      line_q      <= line_d;
      seen_q      <= seen_d;
      prev_lf_q   <= prev_lf_d;
    end
  end

  // output stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_acc && res_valid) begin
      if (out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  // output stage payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (in_acc && res_valid) begin
      if (out_valid_q && !out_take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign kind_o        = out_q.kind;
  assign distance_o    = out_q.distance;
  assign value_index_o = out_q.idx;
  assign scan_count_o  = out_q.cnt;

`include "range_scan_reply_parser_assert.svh"

  `RSRP_ASSERT(a_skid_needs_out, !skid_valid_q || out_valid_q, "skid full with output empty")
  `RSRP_ASSERT(a_seen_cap, seen_q <= SeenW'(MAX_VALUES), "value count past capacity")
  `RSRP_ASSERT(a_grp_range, grp_q != 2'd3, "group position out of range")
  `RSRP_ASSERT(a_bad_status_local, stat_good_q || phase_q == PH_STATUS, "status flag left low")
  `RSRP_ASSERT_NEXT(a_skid_fill, in_acc && res_valid && out_valid_q && out_stall_i, skid_valid_q, "result lost while output stalled")

endmodule

FILE: test/range_scan_reply_parser_tb.sv
// testbench for range_scan_reply_parser: feeds MD replies byte by byte and
// checks every result against an in-bench parser of the same reply format
// depends on rsrp_pkg and the range_scan_reply_parser rtl
module range_scan_reply_parser_tb
  import rsrp_pkg::*;
;

  localparam int unsigned CAPACITY = MAX_VALUES_DEF;
  localparam int unsigned STUCK_LIMIT = 2000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [ByteW-1:0]   rx_byte_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         kind_o;
  logic [DistW-1:0]   distance_o;
  logic [IdxW-1:0]    value_index_o;
  logic [CountW-1:0]  scan_count_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [AddrW-1:0]   paddr = '0;
  logic [DataW-1:0]   pwdata = '0;
  logic [DataW-1:0]   prdata;
  logic               pready;

  // parser copy
  phase_e             stage;
  logic               saw_m;
  logic [1:0]         status_idx;
  logic               status_ok;
  logic [HeldW-1:0]   partial;
  logic [1:0]         group_cnt;
  logic [CharsW-1:0]  col;
  logic [CountW-1:0]  value_cnt;
  logic               last_was_lf;
  logic [CharsW-1:0]  chars_per_line;

  result_t            results_due[$];
  result_t            want;
  int unsigned        parsed_bytes = 0;
  int unsigned        mismatches = 0;
  int unsigned        quiet_cycles = 0;
  bit                 steady = 1'b0;

  range_scan_reply_parser #(.MAX_VALUES(CAPACITY)) uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void reset_parser();
    stage = PH_ECHO1;
    saw_m = 1'b0;
    status_idx = '0;
    status_ok = 1'b1;
    partial = '0;
    group_cnt = '0;
    col = '0;
    value_cnt = '0;
    last_was_lf = 1'b0;
    chars_per_line = CHARS_RESET;
  endfunction

  function automatic void post_result(input kind_e k, input logic [DistW-1:0] d,
                                      input logic [IdxW-1:0] i,
                                      input logic [CountW-1:0] c);
    result_t r;
    r.kind = k;
    r.distance = d;
    r.idx = i;
    r.cnt = c;
    results_due.push_back(r);
  endfunction

  function automatic void decode_byte(input logic [ByteW-1:0] b);
    logic [CharsW-1:0] per_line;
    logic [ByteW-1:0]  offset;
    logic [CountW-1:0] prior;
    per_line = (chars_per_line < CHARS_MIN) ? CHARS_MIN : chars_per_line;
    offset = b - CH_ZERO;
    if (stage != PH_SKIP) parsed_bytes++;
    case (stage)
      PH_ECHO1: begin
        saw_m = (b == CH_M);
        stage = PH_ECHO2;
      end
      PH_ECHO2: begin
        if (saw_m && b == CH_D) begin
          stage = PH_ECHO_REST;
        end else begin
          stage = PH_SKIP;
          post_result(KIND_BAD_ECHO, '0, '0, '0);
        end
      end
      PH_ECHO_REST: begin
        if (b == CH_LF) begin
          stage = PH_STATUS;
          status_idx = '0;
          status_ok = 1'b1;
        end
      end
      PH_STATUS: begin
        if (status_idx == 2'd3) begin
          status_idx = '0;
          if (status_ok) begin
            stage = PH_STAMP;
          end else begin
            status_ok = 1'b1;
            stage = PH_SKIP;
            post_result(KIND_BAD_STATUS, '0, '0, '0);
          end
        end else begin
          if (status_idx < 2'd2 && b != CH_9) status_ok = 1'b0;
          if (status_idx == 2'd2 && b != CH_B) status_ok = 1'b0;
          status_idx++;
        end
      end
      PH_STAMP: begin
        if (b == CH_LF) begin
          stage = PH_DATA;
          partial = '0;
          group_cnt = '0;
          col = '0;
          value_cnt = '0;
          last_was_lf = 1'b0;
        end
      end
      PH_DATA: begin
        if (b == CH_LF) begin
          col = '0;
          if (last_was_lf) begin
            stage = PH_ECHO1;
            group_cnt = '0;
            partial = '0;
            last_was_lf = 1'b0;
            post_result(KIND_DONE, '0, '0, value_cnt);
          end else begin
            last_was_lf = 1'b1;
          end
        end else begin
          last_was_lf = 1'b0;
          if (col >= per_line - 7'd1) begin
            col = '0;
          end else begin
            col++;
            if (group_cnt < 2'd2) begin
              partial = {partial[5:0], offset[5:0]};
              group_cnt++;
            end else begin
              group_cnt = '0;
              if (value_cnt < CountW'(CAPACITY)) begin
                prior = value_cnt;
                value_cnt++;
                post_result(KIND_DIST, {partial, offset[5:0]}, prior[IdxW-1:0], '0);
              end
              partial = '0;
            end
          end
        end
      end
      default: begin
        if (b == CH_LF) stage = PH_ECHO1;
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (results_due.size() == 0) begin
        $error("result with none pending: kind %0d distance %0d", kind_o, distance_o);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          mismatches++;
        end
        if (distance_o !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, distance_o);
          mismatches++;
        end
        if (value_index_o !== want.idx) begin
          $error("value_index: expected %0d, got %0d", want.idx, value_index_o);
          mismatches++;
        end
        if (scan_count_o !== want.cnt) begin
          $error("scan_count: expected %0d, got %0d", want.cnt, scan_count_o);
          mismatches++;
        end
      end
    end
    out_stall_i <= !steady && ($urandom_range(99) < 21);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STUCK_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    if (!steady && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    decode_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [ByteW-1:0] any_but_lf();
    logic [ByteW-1:0] v;
    v = ByteW'($urandom_range(255));
    if (v == CH_LF) v = 8'h0B;
    return v;
  endfunction

  function automatic logic [ByteW-1:0] data_char();
    if ($urandom_range(9) == 0) return any_but_lf();
    return CH_ZERO + ByteW'($urandom_range(63));
  endfunction

  task automatic send_line(input int unsigned n);
    repeat (n) send_byte(any_but_lf());
    send_byte(CH_LF);
  endtask

  task automatic send_header();
    send_text("MD");
    send_line($urandom_range(3));
    send_text("99b");
    send_byte(ByteW'($urandom_range(255)));
    send_line($urandom_range(4));
  endtask

  // data lines with a checksum char at the end of each full line, then the empty line
  task automatic send_data(input int unsigned nchars);
    int unsigned per_line;
    int unsigned pos;
    bit ended;
    per_line = 32'((chars_per_line < CHARS_MIN) ? CHARS_MIN : chars_per_line);
    pos = 0;
    ended = 1'b0;
    for (int unsigned i = 0; i < nchars; i++) begin
      send_byte(data_char());
      ended = 1'b0;
      pos++;
      if (pos == per_line - 1) begin
        send_byte(data_char());
        pos = 0;
        if ($urandom_range(9) != 0) begin
          send_byte(CH_LF);
          ended = 1'b1;
        end
      end
    end
    if (pos != 0) begin
      send_byte(data_char());
      ended = 1'b0;
    end
    if (!ended) send_byte(CH_LF);
    send_byte(CH_LF);
  endtask

  task automatic send_scan(input int unsigned nvals, input int unsigned extra);
    send_header();
    send_data(3 * nvals + extra);
  endtask

  task automatic resync();
    while (stage != PH_ECHO1) send_byte(CH_LF);
  endtask

  task automatic settle_outputs();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_chars(input logic [DataW-1:0] v);
    settle_outputs();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_CHARS, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    chars_per_line = v[CharsW-1:0];
  endtask

  task automatic test_default_register();
    send_scan(25, 1);
  endtask

  task automatic test_bad_echo();
    send_text("MX junk\n");
    send_text("XD\n");
    send_text("M\n\n");
    resync();
  endtask

  task automatic test_bad_status();
    send_text("MD\nX9b?\n");
    send_text("MD\n9Xb?\n");
    send_text("MD\n99c?\n");
    send_text("MD\n99b\n\n\n\n");
  endtask

  task automatic test_char_extremes();
    logic [ByteW-1:0] odd[14];
    odd = '{8'h30, 8'h30, 8'h30, 8'h6F, 8'h6F, 8'h6F, 8'h00, 8'hFF, 8'h2F,
            8'h80, 8'h7F, 8'h55, 8'hAA, 8'h31};
    send_header();
    foreach (odd[i]) send_byte(odd[i]);
    send_byte(CH_LF);
    send_byte(CH_LF);
  endtask

  task automatic test_register_extremes();
    logic [DataW-1:0] vals[6];
    vals = '{32'd0, 32'd1, 32'hFFFF_FF80, 32'd2, 32'd127, 32'hFFFF_FFC1};
    foreach (vals[i]) begin
      write_chars(vals[i]);
      send_scan(5, $urandom_range(2));
    end
    // line that runs on past several checksum positions
    write_chars(32'd4);
    send_text("MD\n99b \n\n012c345c678c\n\n");
  endtask

  task automatic test_capacity();
    write_chars(32'd127);
    send_scan(CAPACITY + 6, 2);
  endtask

  task automatic test_random();
    int unsigned goal;
    int unsigned k;
    int unsigned pick;
    goal = parsed_bytes + 1700;
    k = 0;
    while (parsed_bytes < goal) begin
      steady = (k >= 40 && k < 70);
      if (k == 25) settle_outputs();
      if (k % 12 == 11) begin
        case ($urandom_range(5))
          0: write_chars(32'd2);
          1: write_chars(32'd127);
          2: write_chars(32'd4);
          3: write_chars($urandom_range(2, 127));
          4: write_chars(DataW'(CHARS_RESET));
          default: write_chars($urandom_range(127));
        endcase
      end
      pick = $urandom_range(99);
      if (pick < 65) begin
        resync();
        if ($urandom_range(3) == 0) send_scan($urandom_range(13, 60), $urandom_range(2));
        else send_scan($urandom_range(12), $urandom_range(2));
      end else if (pick < 75) begin
        resync();
        send_byte($urandom_range(1) ? CH_M : any_but_lf());
        send_byte($urandom_range(1) ? CH_D : ByteW'($urandom_range(255)));
        send_line($urandom_range(4));
      end else if (pick < 85) begin
        resync();
        send_text("MD");
        send_line($urandom_range(3));
        repeat (3) send_byte($urandom_range(2) == 0 ? CH_9 :
                             ($urandom_range(1) ? CH_B : ByteW'($urandom_range(255))));
        send_byte(ByteW'($urandom_range(255)));
        send_line($urandom_range(4));
      end else begin
        repeat ($urandom_range(1, 20))
          send_byte($urandom_range(9) == 0 ? CH_LF : ByteW'($urandom_range(255)));
      end
      k++;
    end
    steady = 1'b0;
  endtask

  initial begin
    reset_parser();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_register();
    test_bad_echo();
    test_bad_status();
    test_char_extremes();
    test_register_extremes();
    test_capacity();
    test_random();
    settle_outputs();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
